FILE: src/yblpd_pkg.sv
// shared types, widths and constants for the yiq lip pixel detector
package yblpd_pkg;

	localparam int CHAN_W      = 8;
	localparam int SAMPLE_W    = 19;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 9;

	typedef logic [CHAN_W-1:0]             chan_t;
	typedef logic signed [SAMPLE_W-1:0]    sample_t;
	typedef logic [CFG_INDEX_W-1:0]        cfg_index_t;
	typedef logic [CFG_DATA_W-1:0]         cfg_data_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_LUMA_LOW        = 3'd0,
		REG_LUMA_HIGH       = 3'd1,
		REG_INPHASE_LOW     = 3'd2,
		REG_INPHASE_HIGH    = 3'd3,
		REG_QUADRATURE_LOW  = 3'd4,
		REG_QUADRATURE_HIGH = 3'd5
	} cfg_reg_t;

	// coefficients scaled by 1000
	localparam sample_t K_YR = 19'sd299;
	localparam sample_t K_YG = 19'sd587;
	localparam sample_t K_YB = 19'sd114;
	localparam sample_t K_IR = 19'sd596;
	localparam sample_t K_IG = 19'sd275;
	localparam sample_t K_IB = 19'sd321;
	localparam sample_t K_QR = 19'sd212;
	localparam sample_t K_QG = 19'sd523;
	localparam sample_t K_QB = 19'sd311;
	localparam sample_t SCALE = 19'sd1000;

	// thresholds after reset, already scaled
	localparam sample_t RST_LUMA_LOW        = 19'sd80000;
	localparam sample_t RST_LUMA_HIGH       = 19'sd220000;
	localparam sample_t RST_INPHASE_LOW     = 19'sd12000;
	localparam sample_t RST_INPHASE_HIGH    = 19'sd78000;
	localparam sample_t RST_QUADRATURE_LOW  = 19'sd7000;
	localparam sample_t RST_QUADRATURE_HIGH = 19'sd25000;

	localparam chan_t CHAN_MAX  = 8'd255;
	localparam chan_t CHAN_ZERO = 8'd0;

	function automatic sample_t mul_chan(chan_t c, sample_t k);
		sample_t ext;
		ext = $signed({{(SAMPLE_W-CHAN_W){1'b0}}, c});
		return ext * k;
	endfunction

endpackage

FILE: src/yblpd_stream_if.sv
// valid/ready stream interfaces for pixels in and results out
interface yblpd_pixel_if;
	import yblpd_pkg::*;
	logic  valid;
	logic  ready;
	chan_t red;
	chan_t green;
	chan_t blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface yblpd_result_if;
	import yblpd_pkg::*;
	logic  valid;
	logic  ready;
	chan_t red_out;
	chan_t green_out;
	chan_t blue_out;
	logic  is_lip;

	modport source (output valid, output red_out, output green_out, output blue_out,
		output is_lip, input ready);
	modport sink   (input valid, input red_out, input green_out, input blue_out,
		input is_lip, output ready);
endinterface

FILE: src/yiq_box_lip_pixel_detect_core.sv
// top level: rgb to yiq conversion, window test and magenta marking
// pipeline: a pixel transaction passes the multiply, sum and compare registers in turn before
// its result is offered; one pixel per clock while result.ready is high, and each stage holds
// only while the one after it is full and stalled, so a waiting result does not block intake
// into emptier stages
// reset: arst_n clears all valid bits and loads the default thresholds
module yiq_box_lip_pixel_detect_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  yblpd_pkg::cfg_index_t  cfg_index,
	input  yblpd_pkg::cfg_data_t   cfg_data,
	yblpd_pixel_if.sink            pixel,
	yblpd_result_if.source         result
);
	import yblpd_pkg::*;

	sample_t lo_y_q, hi_y_q, lo_i_q, hi_i_q, lo_q_q, hi_q_q;
	sample_t cfg_luma_scaled, cfg_chroma_scaled;

	assign cfg_luma_scaled   = mul_chan(cfg_data[CHAN_W-1:0], SCALE);
	assign cfg_chroma_scaled = sample_t'($signed(cfg_data)) * SCALE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_y_q <= RST_LUMA_LOW;
			hi_y_q <= RST_LUMA_HIGH;
			lo_i_q <= RST_INPHASE_LOW;
			hi_i_q <= RST_INPHASE_HIGH;
			lo_q_q <= RST_QUADRATURE_LOW;
			hi_q_q <= RST_QUADRATURE_HIGH;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_LUMA_LOW:        lo_y_q <= cfg_luma_scaled;
				REG_LUMA_HIGH:       hi_y_q <= cfg_luma_scaled;
				REG_INPHASE_LOW:     lo_i_q <= cfg_chroma_scaled;
				REG_INPHASE_HIGH:    hi_i_q <= cfg_chroma_scaled;
				REG_QUADRATURE_LOW:  lo_q_q <= cfg_chroma_scaled;
				REG_QUADRATURE_HIGH: hi_q_q <= cfg_chroma_scaled;
				default: ;
			endcase
		end
	end

	logic valid_s1, valid_s2, valid_s3;
	logic adv_s1, adv_s2, adv_s3;

	assign adv_s3      = !valid_s3 || result.ready;
	assign adv_s2      = !valid_s2 || adv_s3;
	assign adv_s1      = !valid_s1 || adv_s2;
	assign pixel.ready = adv_s1;

	// stage 1: constant products
	chan_t   r_s1, g_s1, b_s1;
	sample_t yr_s1, yg_s1, yb_s1, ir_s1, ig_s1, ib_s1, qr_s1, qg_s1, qb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && pixel.valid) begin
			r_s1  <= pixel.red;
			g_s1  <= pixel.green;
			b_s1  <= pixel.blue;
			yr_s1 <= mul_chan(pixel.red,   K_YR);
			yg_s1 <= mul_chan(pixel.green, K_YG);
			yb_s1 <= mul_chan(pixel.blue,  K_YB);
			ir_s1 <= mul_chan(pixel.red,   K_IR);
			ig_s1 <= mul_chan(pixel.green, K_IG);
			ib_s1 <= mul_chan(pixel.blue,  K_IB);
			qr_s1 <= mul_chan(pixel.red,   K_QR);
			qg_s1 <= mul_chan(pixel.green, K_QG);
			qb_s1 <= mul_chan(pixel.blue,  K_QB);
		end
	end

	// stage 2: component sums
	chan_t   r_s2, g_s2, b_s2;
	sample_t y_s2, i_s2, q_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			r_s2 <= r_s1;
			g_s2 <= g_s1;
			b_s2 <= b_s1;
			y_s2 <= yr_s1 + yg_s1 + yb_s1;
			i_s2 <= ir_s1 - ig_s1 - ib_s1;
			q_s2 <= qr_s1 - qg_s1 + qb_s1;
		end
	end

	// stage 3: window test and output select
	logic hit;

	assign hit = (y_s2 >= lo_y_q) && (y_s2 <= hi_y_q)
		&& (i_s2 >= lo_i_q) && (i_s2 <= hi_i_q)
		&& (q_s2 >= lo_q_q) && (q_s2 <= hi_q_q);

	chan_t r_s3, g_s3, b_s3;
	logic  lip_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && valid_s2) begin
			lip_s3 <= hit;
			r_s3   <= hit ? CHAN_MAX  : r_s2;
			g_s3   <= hit ? CHAN_ZERO : g_s2;
			b_s3   <= hit ? CHAN_MAX  : b_s2;
		end
	end

	assign result.valid     = valid_s3;
	assign result.red_out   = r_s3;
	assign result.green_out = g_s3;
	assign result.blue_out  = b_s3;
	assign result.is_lip    = lip_s3;

endmodule

FILE: src/yblpd_checker.sv
// port-level checks for the lip pixel detector, bound to the top level
module yblpd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               pix_valid,
	input logic               pix_ready,
	input logic               res_valid,
	input logic               res_ready,
	input yblpd_pkg::chan_t   res_red,
	input yblpd_pkg::chan_t   res_green,
	input yblpd_pkg::chan_t   res_blue,
	input logic               res_lip
);
	import yblpd_pkg::*;

	// marked pixels are always magenta
	a_lip_magenta: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_lip |-> res_red == CHAN_MAX && res_green == CHAN_ZERO
			&& res_blue == CHAN_MAX)
		else $error("lip result is not magenta");

	// an accepted transaction reaches the output when the sink keeps up
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && pix_ready) ##1 res_ready ##1 res_ready |=> res_valid)
		else $error("accepted pixel did not appear after three cycles");

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_red) && $stable(res_green)
			&& $stable(res_blue) && $stable(res_lip))
		else $error("result payload changed while stalled");

endmodule

bind yiq_box_lip_pixel_detect_core yblpd_checker u_yblpd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pixel.valid),
	.pix_ready (pixel.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_red   (result.red_out),
	.res_green (result.green_out),
	.res_blue  (result.blue_out),
	.res_lip   (result.is_lip)
);

FILE: test/yiq_box_lip_pixel_detect_core_tb.sv
// testbench for the yiq lip pixel detector: directed window cases, random windows, random stalls
module yiq_box_lip_pixel_detect_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import yblpd_pkg::*;

	localparam int PIPE_LATENCY = 3;
	localparam int STALL_LIMIT  = 400;
	localparam int REPORT_LIMIT = 10;
	localparam cfg_index_t SPARE_INDEX_A = 3'd6;
	localparam cfg_index_t SPARE_INDEX_B = 3'd7;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
		logic  is_lip;
	} lip_pixel_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_wr_en;
	cfg_index_t cfg_index;
	cfg_data_t  cfg_data;

	yblpd_pixel_if  pixel_bus ();
	yblpd_result_if result_bus ();

	yiq_box_lip_pixel_detect_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel     (pixel_bus),
		.result    (result_bus)
	);

	// window thresholds as the block holds them
	chan_t             luma_lo_q;
	chan_t             luma_hi_q;
	logic signed [8:0] inphase_lo_q;
	logic signed [8:0] inphase_hi_q;
	logic signed [8:0] quad_lo_q;
	logic signed [8:0] quad_hi_q;

	lip_pixel_t expected_pixels[$];
	int         fault_count = 0;
	int         idle_cycles = 0;
	int         burst_left;
	int         src_gap_max;
	int         sink_mode;
	int         ready_run = 0;
	logic       ready_level = 1'b1;

	always #6 clk = ~clk;

	function automatic void scaled_yiq(input chan_t r, input chan_t g, input chan_t b,
		output int luma, output int inphase, output int quad);
		luma    = 299 * int'(r) + 587 * int'(g) + 114 * int'(b);
		inphase = 596 * int'(r) - 275 * int'(g) - 321 * int'(b);
		quad    = 212 * int'(r) - 523 * int'(g) + 311 * int'(b);
	endfunction

	function automatic lip_pixel_t predict_marking(chan_t r, chan_t g, chan_t b);
		int         luma;
		int         inphase;
		int         quad;
		logic       hit;
		lip_pixel_t res;
		scaled_yiq(r, g, b, luma, inphase, quad);
		hit = luma >= int'(luma_lo_q) * 1000 && luma <= int'(luma_hi_q) * 1000
			&& inphase >= int'(inphase_lo_q) * 1000 && inphase <= int'(inphase_hi_q) * 1000
			&& quad >= int'(quad_lo_q) * 1000 && quad <= int'(quad_hi_q) * 1000;
		if (hit) begin
			res.red    = CHAN_MAX;
			res.green  = CHAN_ZERO;
			res.blue   = CHAN_MAX;
			res.is_lip = 1'b1;
		end else begin
			res.red    = r;
			res.green  = g;
			res.blue   = b;
			res.is_lip = 1'b0;
		end
		return res;
	endfunction

	function automatic int floor_thousand(int x);
		return (x >= 0) ? x / 1000 : -((999 - x) / 1000);
	endfunction

	function automatic int clamp_int(int v, int lo, int hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	function automatic chan_t near_channel(chan_t c);
		return chan_t'(clamp_int(int'(c) + int'($urandom_range(0, 20)) - 10, 0, 255));
	endfunction

	task automatic note_fault(input string msg);
		fault_count++;
		if (fault_count <= REPORT_LIMIT)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b);
		int gap;
		if (src_gap_max != 0 && burst_left == 0) begin
			pixel_bus.valid <= 1'b0;
			gap = $urandom_range(1, src_gap_max);
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 20);
		end
		pixel_bus.valid <= 1'b1;
		pixel_bus.red   <= r;
		pixel_bus.green <= g;
		pixel_bus.blue  <= b;
		do @(posedge clk); while (pixel_bus.ready !== 1'b1);
		expected_pixels.insert(expected_pixels.size(), predict_marking(r, g, b));
		if (burst_left != 0)
			burst_left--;
	endtask

	// stop sending and let every pending transaction drain
	task automatic settle();
		pixel_bus.valid <= 1'b0;
		burst_left = 0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY) @(posedge clk);
	endtask

	task automatic write_register(input cfg_index_t idx, input cfg_data_t data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_LUMA_LOW:        luma_lo_q    = data[7:0];
			REG_LUMA_HIGH:       luma_hi_q    = data[7:0];
			REG_INPHASE_LOW:     inphase_lo_q = data;
			REG_INPHASE_HIGH:    inphase_hi_q = data;
			REG_QUADRATURE_LOW:  quad_lo_q    = data;
			REG_QUADRATURE_HIGH: quad_hi_q    = data;
			default: ;
		endcase
	endtask

	task automatic finish_writes();
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_windows(input int luma_lo, input int luma_hi, input int inphase_lo,
		input int inphase_hi, input int quad_lo, input int quad_hi);
		settle();
		write_register(REG_LUMA_LOW, cfg_data_t'(luma_lo));
		write_register(REG_LUMA_HIGH, cfg_data_t'(luma_hi));
		write_register(REG_INPHASE_LOW, cfg_data_t'(inphase_lo));
		write_register(REG_INPHASE_HIGH, cfg_data_t'(inphase_hi));
		write_register(REG_QUADRATURE_LOW, cfg_data_t'(quad_lo));
		write_register(REG_QUADRATURE_HIGH, cfg_data_t'(quad_hi));
		finish_writes();
	endtask

	task automatic check_default_windows();
		src_gap_max = 4;
		sink_mode   = 1;
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd200, 8'd120, 8'd100);
		send_pixel(8'd128, 8'd64, 8'd200);
	endtask

	// windows that just enclose a pixel, both ends inclusive
	task automatic check_window_edges();
		src_gap_max = 0;
		sink_mode   = 2;
		program_windows(0, 0, 0, 0, 0, 0);
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd1, 8'd0, 8'd0);
		program_windows(255, 255, 0, 0, 0, 0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd254, 8'd254, 8'd254);
		program_windows(178, 179, -152, -151, -55, -54);
		send_pixel(8'd0, 8'd255, 8'd255);
		program_windows(76, 77, 151, 152, 54, 55);
		send_pixel(8'd255, 8'd0, 8'd0);
	endtask

	task automatic check_register_extremes();
		src_gap_max = 2;
		sink_mode   = 0;
		settle();
		// luma keeps only its low byte
		write_register(REG_LUMA_LOW, 9'h100);
		write_register(REG_LUMA_HIGH, 9'h1ff);
		write_register(REG_INPHASE_LOW, 9'h100);
		write_register(REG_INPHASE_HIGH, 9'h0ff);
		write_register(REG_QUADRATURE_LOW, 9'h100);
		write_register(REG_QUADRATURE_HIGH, 9'h0ff);
		finish_writes();
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		settle();
		// writes to unused indexes must change nothing
		write_register(SPARE_INDEX_A, 9'h000);
		write_register(SPARE_INDEX_B, 9'h1ff);
		finish_writes();
		send_pixel(8'd17, 8'd200, 8'd93);
		// empty windows, low above high
		program_windows(255, 0, 255, -256, 255, -256);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd0, 8'd0);
	endtask

	task automatic check_random_windows(input int phases, input int per_phase);
		chan_t cr;
		chan_t cg;
		chan_t cb;
		int    luma;
		int    inphase;
		int    quad;
		int    margin;
		int    pick;
		for (int p = 0; p < phases; p++) begin
			cr = chan_t'($urandom_range(0, 255));
			cg = chan_t'($urandom_range(0, 255));
			cb = chan_t'($urandom_range(0, 255));
			if ($urandom_range(0, 3) != 0) begin
				scaled_yiq(cr, cg, cb, luma, inphase, quad);
				margin = $urandom_range(0, 25);
				program_windows(clamp_int(floor_thousand(luma) - margin, 0, 255),
					clamp_int(floor_thousand(luma) + 1 + margin, 0, 255),
					clamp_int(floor_thousand(inphase) - margin, -256, 255),
					clamp_int(floor_thousand(inphase) + 1 + margin, -256, 255),
					clamp_int(floor_thousand(quad) - margin, -256, 255),
					clamp_int(floor_thousand(quad) + 1 + margin, -256, 255));
			end else begin
				settle();
				write_register(REG_LUMA_LOW, cfg_data_t'($urandom_range(0, 511)));
				write_register(REG_LUMA_HIGH, cfg_data_t'($urandom_range(0, 511)));
				write_register(REG_INPHASE_LOW, cfg_data_t'($urandom_range(0, 511)));
				write_register(REG_INPHASE_HIGH, cfg_data_t'($urandom_range(0, 511)));
				write_register(REG_QUADRATURE_LOW, cfg_data_t'($urandom_range(0, 511)));
				write_register(REG_QUADRATURE_HIGH, cfg_data_t'($urandom_range(0, 511)));
				finish_writes();
			end
			src_gap_max = (p % 4 == 0) ? 0 : $urandom_range(1, 8);
			sink_mode   = p % 3;
			for (int n = 0; n < per_phase; n++) begin
				pick = $urandom_range(0, 9);
				if (pick < 6)
					send_pixel(near_channel(cr), near_channel(cg), near_channel(cb));
				else if (pick < 9)
					send_pixel(chan_t'($urandom_range(0, 255)), chan_t'($urandom_range(0, 255)),
						chan_t'($urandom_range(0, 255)));
				else
					send_pixel($urandom_range(0, 1) ? CHAN_MAX : CHAN_ZERO,
						$urandom_range(0, 1) ? CHAN_MAX : CHAN_ZERO,
						$urandom_range(0, 1) ? CHAN_MAX : CHAN_ZERO);
			end
		end
	endtask

	// result side: stall pattern and checking
	always @(posedge clk) begin
		lip_pixel_t want;
		if (arst_n && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
			if (expected_pixels.size() == 0) begin
				note_fault($sformatf("unexpected transaction rgb=%0d,%0d,%0d lip=%0b",
					result_bus.red_out, result_bus.green_out, result_bus.blue_out,
					result_bus.is_lip));
			end else begin
				want = expected_pixels.pop_front();
				if (result_bus.red_out !== want.red)
					note_fault($sformatf("red_out expected %0d got %0d",
						want.red, result_bus.red_out));
				if (result_bus.green_out !== want.green)
					note_fault($sformatf("green_out expected %0d got %0d",
						want.green, result_bus.green_out));
				if (result_bus.blue_out !== want.blue)
					note_fault($sformatf("blue_out expected %0d got %0d",
						want.blue, result_bus.blue_out));
				if (result_bus.is_lip !== want.is_lip)
					note_fault($sformatf("is_lip expected %0b got %0b",
						want.is_lip, result_bus.is_lip));
			end
		end
		if (ready_run == 0) begin
			case (sink_mode)
				0: begin
					ready_level = 1'b1;
					ready_run   = 1;
				end
				1: begin
					ready_level = ($urandom_range(0, 2) != 0);
					ready_run   = 1;
				end
				default: begin
					ready_level = !ready_level;
					ready_run   = ready_level ? $urandom_range(1, 6) : $urandom_range(1, 12);
				end
			endcase
		end
		ready_run--;
		result_bus.ready <= ready_level;
	end

	always @(posedge clk) begin
		if (!arst_n || (pixel_bus.valid === 1'b1 && pixel_bus.ready === 1'b1)
			|| (result_bus.valid === 1'b1 && result_bus.ready === 1'b1)) begin
			idle_cycles = 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("yiq_box_lip_pixel_detect_core_tb NOT OK");
			$finish;
		end else begin
			idle_cycles++;
		end
	end

	initial begin
		arst_n           = 1'b0;
		cfg_wr_en        = 1'b0;
		cfg_index        = REG_LUMA_LOW;
		cfg_data         = '0;
		pixel_bus.valid  = 1'b0;
		pixel_bus.red    = '0;
		pixel_bus.green  = '0;
		pixel_bus.blue   = '0;
		luma_lo_q        = 8'd80;
		luma_hi_q        = 8'd220;
		inphase_lo_q     = 9'sd12;
		inphase_hi_q     = 9'sd78;
		quad_lo_q        = 9'sd7;
		quad_hi_q        = 9'sd25;
		burst_left       = 0;
		src_gap_max      = 0;
		sink_mode        = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_default_windows();
		check_window_edges();
		check_register_extremes();
		check_random_windows(8, 122);
		settle();
		if (fault_count == 0)
			$display("yiq_box_lip_pixel_detect_core_tb OK");
		else
			$display("yiq_box_lip_pixel_detect_core_tb NOT OK");
		$finish;
	end

endmodule
